FILE: rtl/tmu_pkg.sv
// ----------------------------------------------------------------------------
// tmu_pkg
// Item types, sequencer codes and constants for the triangle measure unit.
// ----------------------------------------------------------------------------
package tmu_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [33:0] PI_HALF_Q30 = 34'sd1686629713;
    localparam logic [15:0]        ANGLE_MAX   = 16'd51472;
    localparam logic [15:0]        SIDE_ONE    = 16'd256;

    typedef struct packed {
        logic [15:0] side_a;
        logic [15:0] side_b;
        logic [15:0] side_c;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [17:0] perimeter;
        logic [22:0] area;
        logic [15:0] angle_a;
        logic [15:0] angle_b;
        logic [15:0] angle_c;
        logic [15:0] median_a;
        logic [15:0] median_b;
        logic [15:0] median_c;
        logic        right_angled;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SQ_AREA,
        S_ANG_LOAD,
        S_ANG_NORM,
        S_SQ_ANG,
        S_CORDIC,
        S_ANG_END,
        S_MED_LOAD,
        S_SQ_MED,
        S_FINISH
    } state_t;

    // multiplier schedule
    typedef enum logic [3:0] {
        M_SUM_FA,
        M_FB_FC,
        M_P_LO,
        M_P_HI,
        M_P_ADD,
        M_SQ_A,
        M_SQ_B,
        M_SQ_C,
        M_BC,
        M_AC,
        M_AB
    } mstep_t;

    typedef enum logic [1:0] {
        SIDE_A,
        SIDE_B,
        SIDE_C
    } side_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/triangle_measure_unit_core.sv
// ----------------------------------------------------------------------------
// triangle_measure_unit_core
// Triangle check and measurement: perimeter, Heron area, angles, medians and
// a right-angle flag of the stored triangle, on one shared iterative datapath.
// ----------------------------------------------------------------------------
// One item in, one item out. Between acceptance and a valid result an item
// passes through the multiplier schedule, seven square roots (area, three
// angle radii, three medians), three 30-step CORDIC vectoring runs, and a
// leading-zero walk per angle that scales each angle's vector. s_ready is
// high only while the sequencer is idle. The finished item sits in an output
// register, so a new item can be taken while the previous result still waits
// on m_ready. The tolerance register may be written at any time through the
// cfg channel (ready whenever out of reset); it is sampled when the result is
// formed. After reset the stored sides are 1.0, 1.0, 1.0 and the tolerance is
// zero.
// ----------------------------------------------------------------------------
module triangle_measure_unit_core import tmu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // ---- control state ----
    state_t      state_reg, state_next;
    mstep_t      mstep_reg;
    side_t       k_reg;
    logic        m_valid_reg;
    logic [15:0] sa_reg, sb_reg, sc_reg;   // stored triangle
    logic [15:0] tol_reg;

    // ---- datapath ----
    logic [35:0]        m_reg, n_reg;      // factor pair products
    logic [53:0]        t_reg;             // high partial product
    logic [71:0]        p_reg;             // 16 * area^2
    logic [31:0]        sqa_reg, sqb_reg, sqc_reg;
    logic [31:0]        pbc_reg, pac_reg, pab_reg;
    logic [32:0]        dn_reg;            // 2yz being normalised
    logic signed [5:0]  sh_reg;            // scale exponent s
    logic signed [39:0] xq_reg, vx_reg, vy_reg;
    logic signed [33:0] z_reg;
    logic [4:0]         it_reg;
    logic [63:0]        rad_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [4:0]         scnt_reg;
    out_item_t          res_reg, out_reg;

    // ---- acceptance test ----
    logic cand_ok;
    always_comb begin
        cand_ok = (s_data.side_a != 16'd0) && (s_data.side_b != 16'd0) &&
                  (s_data.side_c != 16'd0) &&
                  (17'(s_data.side_a) + 17'(s_data.side_b) > 17'(s_data.side_c)) &&
                  (17'(s_data.side_a) + 17'(s_data.side_c) > 17'(s_data.side_b)) &&
                  (17'(s_data.side_b) + 17'(s_data.side_c) > 17'(s_data.side_a));
    end

    // ---- shared multiplier, 36 x 18 ----
    logic [17:0] perim, fa, fb, fc;
    logic [35:0] op_a;
    logic [17:0] op_b;
    logic [53:0] prod;

    assign perim = 18'(sa_reg) + 18'(sb_reg) + 18'(sc_reg);
    assign fa    = 18'(sb_reg) + 18'(sc_reg) - 18'(sa_reg);
    assign fb    = 18'(sa_reg) + 18'(sc_reg) - 18'(sb_reg);
    assign fc    = 18'(sa_reg) + 18'(sb_reg) - 18'(sc_reg);

    always_comb begin
        case (mstep_reg)
            M_SUM_FA: begin op_a = 36'(perim);  op_b = fa;           end
            M_FB_FC:  begin op_a = 36'(fb);     op_b = fc;           end
            M_P_LO:   begin op_a = m_reg;       op_b = n_reg[17:0];  end
            M_P_HI:   begin op_a = m_reg;       op_b = n_reg[35:18]; end
            M_SQ_A:   begin op_a = 36'(sa_reg); op_b = 18'(sa_reg);  end
            M_SQ_B:   begin op_a = 36'(sb_reg); op_b = 18'(sb_reg);  end
            M_SQ_C:   begin op_a = 36'(sc_reg); op_b = 18'(sc_reg);  end
            M_BC:     begin op_a = 36'(sb_reg); op_b = 18'(sc_reg);  end
            M_AC:     begin op_a = 36'(sa_reg); op_b = 18'(sc_reg);  end
            M_AB:     begin op_a = 36'(sa_reg); op_b = 18'(sb_reg);  end
            default:  begin op_a = '0;          op_b = '0;           end
        endcase
        prod = op_a * op_b;
    end

    // ---- per-side selection: x opposite, y and z adjacent ----
    logic [31:0] sel_x_sq, sel_y_sq, sel_z_sq, sel_prod;
    always_comb begin
        unique case (k_reg)
            SIDE_A: begin
                sel_x_sq = sqa_reg; sel_y_sq = sqb_reg; sel_z_sq = sqc_reg; sel_prod = pbc_reg;
            end
            SIDE_B: begin
                sel_x_sq = sqb_reg; sel_y_sq = sqa_reg; sel_z_sq = sqc_reg; sel_prod = pac_reg;
            end
            SIDE_C: begin
                sel_x_sq = sqc_reg; sel_y_sq = sqa_reg; sel_z_sq = sqb_reg; sel_prod = pab_reg;
            end
            default: begin
                sel_x_sq = '0; sel_y_sq = '0; sel_z_sq = '0; sel_prod = '0;
            end
        endcase
    end

    // y^2 + z^2 - x^2
    function automatic logic signed [33:0] cos_num(input logic [31:0] x2,
                                                   input logic [31:0] y2,
                                                   input logic [31:0] z2);
        return $signed({2'b00, y2}) + $signed({2'b00, z2}) - $signed({2'b00, x2});
    endfunction

    function automatic logic near_right(input logic signed [33:0] n,
                                        input logic [15:0] tol);
        logic [33:0] mag;
        mag = n[33] ? 34'(-n) : 34'(n);
        return mag <= 34'(tol);
    endfunction

    // ---- angle scaling ----
    logic signed [33:0] n_sel;
    logic signed [39:0] n_ext, x_val;
    logic [5:0]         neg_sh;
    logic [71:0]        p_l, p_r;
    logic [63:0]        ang_rad;
    logic [33:0]        med_rad;

    always_comb begin
        n_sel   = cos_num(sel_x_sq, sel_y_sq, sel_z_sq);
        n_ext   = {{6{n_sel[33]}}, n_sel};
        neg_sh  = 6'(-sh_reg);
        p_l     = p_reg << {sh_reg[4:0], 1'b0};
        p_r     = p_reg >> {neg_sh[4:0], 1'b0};
        if (sh_reg[5]) begin
            x_val   = n_ext >>> neg_sh[4:0];
            ang_rad = p_r[63:0];
        end else begin
            x_val   = n_ext <<< sh_reg[4:0];
            ang_rad = p_l[63:0];
        end
        med_rad = {(33'(sel_y_sq) + 33'(sel_z_sq)), 1'b0} - 34'(sel_x_sq);
    end

    // ---- square root, two radicand bits a cycle ----
    logic [35:0] rem_t, trial;
    logic        sq_ge;
    logic [33:0] rem_n;
    logic [31:0] root_n;
    logic        sqrt_done;

    always_comb begin
        rem_t     = {rem_reg, rad_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        sq_ge     = rem_t >= trial;
        rem_n     = sq_ge ? 34'(rem_t - trial) : rem_t[33:0];
        root_n    = {root_reg[30:0], sq_ge};
        sqrt_done = scnt_reg == 5'(SQRT_STEPS - 1);
    end

    // ---- CORDIC vectoring step ----
    logic signed [39:0] dx, dy, vx_n, vy_n, y_ext;
    logic signed [33:0] atan_v, z_n;
    logic               cordic_done;

    always_comb begin
        dx     = vy_reg >>> it_reg;
        dy     = vx_reg >>> it_reg;
        atan_v = $signed({2'b00, atan_q30(it_reg)});
        if (vy_reg > 40'sd0) begin
            vx_n = vx_reg + dx; vy_n = vy_reg - dy; z_n = z_reg + atan_v;
        end else begin
            vx_n = vx_reg - dx; vy_n = vy_reg + dy; z_n = z_reg - atan_v;
        end
        cordic_done = it_reg == 5'(CORDIC_STEPS - 1);
        y_ext       = $signed({8'b0, root_n});
    end

    // rounding and clamp of the Q30 angle to Q2.14
    logic signed [34:0] z_rnd;
    logic [18:0]        z_q;
    logic [15:0]        ang_val;
    always_comb begin
        z_rnd = {z_reg[33], z_reg} + 35'sd32768;
        z_q   = z_rnd[34:16];
        if (z_rnd[34])                  ang_val = '0;
        else if (z_q > 19'(ANGLE_MAX))  ang_val = ANGLE_MAX;
        else                            ang_val = z_q[15:0];
    end

    // ---- finished item ----
    logic      right_flag;
    out_item_t fin_item;
    always_comb begin
        right_flag = near_right(cos_num(sqc_reg, sqa_reg, sqb_reg), tol_reg) ||
                     near_right(cos_num(sqb_reg, sqa_reg, sqc_reg), tol_reg) ||
                     near_right(cos_num(sqa_reg, sqb_reg, sqc_reg), tol_reg);
        fin_item              = res_reg;
        fin_item.right_angled = right_flag;
    end

    // ---- sequencer ----
    logic accept_in, load_out;
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid) state_next = S_MUL;
            end
            S_MUL:      if (mstep_reg == M_AB) state_next = S_SQ_AREA;
            S_SQ_AREA:  if (sqrt_done) state_next = S_ANG_LOAD;
            S_ANG_LOAD: state_next = S_ANG_NORM;
            S_ANG_NORM: if (dn_reg[32]) state_next = S_SQ_ANG;
            S_SQ_ANG:   if (sqrt_done) state_next = S_CORDIC;
            S_CORDIC:   if (cordic_done) state_next = S_ANG_END;
            S_ANG_END:  state_next = (k_reg == SIDE_C) ? S_MED_LOAD : S_ANG_LOAD;
            S_MED_LOAD: state_next = S_SQ_MED;
            S_SQ_MED: begin
                if (sqrt_done) state_next = (k_reg == SIDE_C) ? S_FINISH : S_MED_LOAD;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign accept_in = s_valid && s_ready;
    assign cfg_ready = aresetn;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            sa_reg      <= SIDE_ONE;
            sb_reg      <= SIDE_ONE;
            sc_reg      <= SIDE_ONE;
            tol_reg     <= '0;
            mstep_reg   <= M_SUM_FA;
            k_reg       <= SIDE_A;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) tol_reg <= cfg_data;
            if (load_out)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (accept_in) begin
                mstep_reg <= M_SUM_FA;
                if (cand_ok) begin
                    sa_reg <= s_data.side_a;
                    sb_reg <= s_data.side_b;
                    sc_reg <= s_data.side_c;
                end
            end
            if (state_reg == S_MUL && mstep_reg != M_AB) mstep_reg <= mstep_t'(mstep_reg + 4'd1);
            if (state_reg == S_SQ_AREA && sqrt_done) k_reg <= SIDE_A;
            if (state_reg == S_ANG_END) k_reg <= (k_reg == SIDE_C) ? SIDE_A : side_t'(k_reg + 2'd1);
            if (state_reg == S_SQ_MED && sqrt_done && k_reg != SIDE_C) begin
                k_reg <= side_t'(k_reg + 2'd1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            res_reg.accepted     <= cand_ok;
            res_reg.right_angled <= 1'b0;   // replaced when the result is formed
        end
        if (load_out)  out_reg <= fin_item;

        // square root iteration runs in every root state
        if (state_reg == S_SQ_AREA || state_reg == S_SQ_ANG || state_reg == S_SQ_MED) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= rem_n;
            root_reg <= root_n;
            scnt_reg <= scnt_reg + 5'd1;
        end

        unique case (state_reg)
            S_MUL: begin
                case (mstep_reg)
                    M_SUM_FA: m_reg   <= prod[35:0];
                    M_FB_FC:  n_reg   <= prod[35:0];
                    M_P_LO:   p_reg   <= 72'(prod);
                    M_P_HI:   t_reg   <= prod;
                    M_P_ADD:  p_reg   <= p_reg + (72'(t_reg) << 18);
                    M_SQ_A:   sqa_reg <= prod[31:0];
                    M_SQ_B:   sqb_reg <= prod[31:0];
                    M_SQ_C:   sqc_reg <= prod[31:0];
                    M_BC:     pbc_reg <= prod[31:0];
                    M_AC:     pac_reg <= prod[31:0];
                    M_AB:     pab_reg <= prod[31:0];
                    default:  ;
                endcase
                if (mstep_reg == M_AB) begin
                    res_reg.perimeter <= perim;
                    rad_reg  <= p_reg[71:8] >> 12;   // P >> 20
                    rem_reg  <= '0;
                    root_reg <= '0;
                    scnt_reg <= '0;
                end
            end
            S_SQ_AREA: if (sqrt_done) res_reg.area <= root_n[22:0];
            S_ANG_LOAD: begin
                dn_reg <= {sel_prod, 1'b0};
                sh_reg <= -6'sd2;
            end
            S_ANG_NORM: begin
                if (dn_reg[32]) begin
                    xq_reg   <= x_val;
                    rad_reg  <= ang_rad;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    scnt_reg <= '0;
                end else begin
                    dn_reg <= {dn_reg[31:0], 1'b0};
                    sh_reg <= sh_reg + 6'sd1;
                end
            end
            S_SQ_ANG: begin
                if (sqrt_done) begin
                    it_reg <= '0;
                    // left half-plane: pre-turn by -90 degrees
                    if (xq_reg < 40'sd0) begin
                        vx_reg <= y_ext;
                        vy_reg <= -xq_reg;
                        z_reg  <= PI_HALF_Q30;
                    end else begin
                        vx_reg <= xq_reg;
                        vy_reg <= y_ext;
                        z_reg  <= '0;
                    end
                end
            end
            S_CORDIC: begin
                vx_reg <= vx_n;
                vy_reg <= vy_n;
                z_reg  <= z_n;
                it_reg <= it_reg + 5'd1;
            end
            S_ANG_END: begin
                case (k_reg)
                    SIDE_A:  res_reg.angle_a <= ang_val;
                    SIDE_B:  res_reg.angle_b <= ang_val;
                    SIDE_C:  res_reg.angle_c <= ang_val;
                    default: ;
                endcase
            end
            S_MED_LOAD: begin
                rad_reg  <= 64'(med_rad);
                rem_reg  <= '0;
                root_reg <= '0;
                scnt_reg <= '0;
            end
            S_SQ_MED: begin
                if (sqrt_done) begin
                    case (k_reg)
                        SIDE_A:  res_reg.median_a <= root_n[16:1];
                        SIDE_B:  res_reg.median_b <= root_n[16:1];
                        SIDE_C:  res_reg.median_c <= root_n[16:1];
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // busy straight after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while sequencer busy");

    // results only appear from the finish step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish step");

    // stored sides always form a proper triangle
    a_stored_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        sa_reg != 16'd0 && sb_reg != 16'd0 && sc_reg != 16'd0 &&
        17'(sa_reg) + 17'(sb_reg) > 17'(sc_reg) &&
        17'(sa_reg) + 17'(sc_reg) > 17'(sb_reg) &&
        17'(sb_reg) + 17'(sc_reg) > 17'(sa_reg))
        else $error("stored sides do not form a triangle");
`endif

endmodule

FILE: sim/triangle_measure_unit_core_tb.sv
// ----------------------------------------------------------------------------
// triangle_measure_unit_core_tb
// Self-checking bench for the triangle measure unit. A bit-exact predictor
// tracks the stored sides and the tolerance register. It works out each
// measurement item as soon as an item is accepted, and a monitor compares
// every result item field by field. Directed corner items come first, then
// tolerance sweeps, long back-pressure and random triangles under several
// idling mixes.
// ----------------------------------------------------------------------------
module triangle_measure_unit_core_tb;
    import tmu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 500;
    localparam int HOLD_CYCLES    = 1500;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predictor state: stored triangle and tolerance copy
    logic [15:0] tri_a, tri_b, tri_c;
    logic [15:0] tol_reg;

    out_item_t   measure_q[$];
    int          mismatches;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          recv_hold;

    triangle_measure_unit_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r    = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // angle opposite x, atan2 of the scaled (cos, sin) vector by CORDIC
    function automatic logic [15:0] cordic_angle(input logic [63:0] x, input logic [63:0] y,
                                                 input logic [63:0] z, input logic [127:0] p);
        longint      n, vx, vy, acc, t, dx, dy;
        logic [63:0] d, tmp, pl;
        int          blen, s;
        n    = longint'(y * y + z * z) - longint'(x * x);
        d    = 2 * y * z;
        blen = 0;
        tmp  = d;
        while (tmp != 0) begin
            blen++;
            tmp = tmp >> 1;
        end
        s   = 31 - blen;
        acc = 0;
        if (s >= 0) begin
            vx = n * (longint'(1) << s);
            pl = p[63:0] << (2 * s);
            vy = longint'(int_sqrt(pl));
        end else begin
            vx = n >>> (-s);
            pl = 64'(p >> (-2 * s));
            vy = longint'(int_sqrt(pl));
        end
        // left half-plane: rotate by -90 degrees first
        if (vx < 0) begin
            t   = vx;
            vx  = vy;
            vy  = -t;
            acc = longint'(PI_HALF_Q30);
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + longint'(atan_q30(5'(i)));
            end else begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - longint'(atan_q30(5'(i)));
            end
        end
        acc = acc + 32768;
        if (acc < 0) acc = 0;
        acc = acc >>> 16;
        if (acc > longint'(ANGLE_MAX)) acc = longint'(ANGLE_MAX);
        return 16'(acc);
    endfunction

    function automatic logic [15:0] median_len(input logic [63:0] x, input logic [63:0] y,
                                               input logic [63:0] z);
        return 16'(int_sqrt(2 * y * y + 2 * z * z - x * x) >> 1);
    endfunction

    function automatic bit near_square(input logic [63:0] x, input logic [63:0] y,
                                       input logic [63:0] z);
        longint m;
        m = longint'(y * y + z * z) - longint'(x * x);
        if (m < 0) m = -m;
        return m <= longint'({48'd0, tol_reg});
    endfunction

    // updates the stored triangle and returns its measurements
    function automatic out_item_t measure_triangle(input in_item_t cand);
        out_item_t    r;
        logic [63:0]  a, b, c, ca, cb, cc, f1, f2;
        logic [127:0] p;
        bit           ok;
        ca = {48'd0, cand.side_a};
        cb = {48'd0, cand.side_b};
        cc = {48'd0, cand.side_c};
        ok = ca > 0 && cb > 0 && cc > 0 && ca + cb > cc && ca + cc > cb && cb + cc > ca;
        if (ok) begin
            tri_a = cand.side_a;
            tri_b = cand.side_b;
            tri_c = cand.side_c;
        end
        a  = {48'd0, tri_a};
        b  = {48'd0, tri_b};
        c  = {48'd0, tri_c};
        f1 = (a + b + c) * (b + c - a);
        f2 = (a + c - b) * (a + b - c);
        p  = {64'd0, f1} * {64'd0, f2};
        r.accepted     = ok;
        r.perimeter    = 18'(a + b + c);
        r.area         = 23'(int_sqrt(64'(p >> 20)));
        r.angle_a      = cordic_angle(a, b, c, p);
        r.angle_b      = cordic_angle(b, a, c, p);
        r.angle_c      = cordic_angle(c, a, b, p);
        r.median_a     = median_len(a, b, c);
        r.median_b     = median_len(b, a, c);
        r.median_c     = median_len(c, a, b);
        r.right_angled = near_square(c, a, b) || near_square(b, a, c) || near_square(a, b, c);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    function automatic void note_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (measure_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_data);
            end else begin
                want = measure_q.pop_front();
                note_field("accepted", want.accepted, m_data.accepted);
                note_field("perimeter", want.perimeter, m_data.perimeter);
                note_field("area", want.area, m_data.area);
                note_field("angle_a", want.angle_a, m_data.angle_a);
                note_field("angle_b", want.angle_b, m_data.angle_b);
                note_field("angle_c", want.angle_c, m_data.angle_c);
                note_field("median_a", want.median_a, m_data.median_a);
                note_field("median_b", want.median_b, m_data.median_b);
                note_field("median_c", want.median_c, m_data.median_c);
                note_field("right_angled", want.right_angled, m_data.right_angled);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles in which no item moves on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // valid is only dropped when a gap follows, never lowered and raised in one step
    task automatic send_item(input logic [15:0] sa, input logic [15:0] sb,
                             input logic [15:0] sc);
        in_item_t it;
        it = '{side_a: sa, side_b: sb, side_c: sc};
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        measure_q.push_back(measure_triangle(it));
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (measure_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // tolerance write, only ever issued with the unit drained
    task automatic write_tolerance(input logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tol_reg = v;
    endtask

    task automatic send_triangle;
        logic [15:0] a, b, lo, hi;
        int          scale;
        scale = $urandom_range(3);
        // most items small, some full range
        a  = (scale == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 255 << scale * 2));
        b  = (scale == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 255 << scale * 2));
        lo = (a > b) ? a - b + 1 : b - a + 1;
        hi = (32'(a) + 32'(b) - 1 > 65535) ? 16'd65535 : a + b - 1;
        send_item(a, b, 16'($urandom_range(lo, hi)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_corner_items;
        send_item(16'd0, 16'd0, 16'd0);          // reset triangle reported
        send_item(16'd65535, 16'd65535, 16'd65535);
        send_item(16'd1, 16'd1, 16'd1);
        send_item(16'd0, 16'd300, 16'd300);      // zero side
        send_item(16'd300, 16'd0, 16'd300);
        send_item(16'd300, 16'd300, 16'd0);
        send_item(16'd256, 16'd512, 16'd768);    // degenerate
        send_item(16'd768, 16'd256, 16'd512);
        send_item(16'd512, 16'd768, 16'd256);
        send_item(16'd768, 16'd1024, 16'd1280);  // exact right
        send_item(16'd1280, 16'd768, 16'd1024);
        send_item(16'd65535, 16'd65535, 16'd1);  // needle
        send_item(16'd1, 16'd65535, 16'd65535);
        send_item(16'd65535, 16'd32768, 16'd32768); // very obtuse
        send_item(16'd32768, 16'd65535, 16'd32768);
        send_item(16'd32768, 16'd32768, 16'd65535);
        send_item(16'd65535, 16'd0, 16'd65535);
        send_item(16'd43690, 16'd21845, 16'd43690);
        send_item(16'd2, 16'd3, 16'd4);
    endtask

    task automatic test_tolerance;
        logic [15:0] tols[4];
        tols = '{16'd65535, 16'd300, 16'($urandom_range(1, 65534)), 16'd0};
        foreach (tols[k]) begin
            write_tolerance(tols[k]);
            send_item(16'd768, 16'd1024, 16'd1281);  // near right
            send_item(16'd3000, 16'd4000, 16'd5001);
            send_item(16'd200, 16'd210, 16'd290);
            send_item(16'd10, 16'd10, 16'd14);
            repeat (8) send_triangle();
        end
    endtask

    task automatic test_backpressure;
        recv_hold = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge aclk);
                recv_hold = 1'b0;
            end
            repeat (8) send_triangle();
        join
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct, input int count);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 70)
                send_triangle();
            else
                send_item(16'($urandom), 16'($urandom), 16'($urandom));
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        m_ready        = 1'b0;
        recv_hold      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        tri_a          = SIDE_ONE;
        tri_b          = SIDE_ONE;
        tri_c          = SIDE_ONE;
        tol_reg        = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_items();
        test_tolerance();
        test_backpressure();
        test_random_phase(0, 0, 400);
        write_tolerance(16'($urandom_range(0, 4000)));
        test_random_phase(74, 0, 400);
        test_random_phase(0, 74, 400);
        write_tolerance(16'd65535);
        test_random_phase(12, 12, 500);
        drain();

        if (mismatches == 0 && measure_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
